/* design/pwsf_pkg.sv */
`default_nettype none

package pwsf_pkg;

    // Fixed point and storage sizing
    localparam int GAIN_FRAC_BITS = 16;
    localparam int ACC_WIDTH      = 41;

    // Field widths
    localparam int GAIN_W     = 32;
    localparam int DATA_W     = 32;
    localparam int ERR_W      = DATA_W + 1;
    localparam int ELAPSED_W  = 24;
    localparam int DUTY_W     = 16;
    localparam int LIMIT_W    = 40;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;

    // Each P, I and D term is held to +/- 2^TERM_LIM_LOG before the sum
    localparam int TERM_LIM_LOG = 60;
    localparam int USEC_PER_SEC = 1000000;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_STATIC    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd4;

endpackage

`default_nettype wire

/* design/pwsf_in_if.sv */
`default_nettype none

interface pwsf_in_if
    import pwsf_pkg::*;
;
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic                        restart;
    logic signed [DATA_W-1:0]    measured;
    logic signed [DATA_W-1:0]    setpoint;
    logic signed [DATA_W-1:0]    velocity;
    logic        [ELAPSED_W-1:0] elapsed_us;

    modport source (
        output valid, mode, restart, measured, setpoint, velocity, elapsed_us,
        input  ready
    );

    modport sink (
        input  valid, mode, restart, measured, setpoint, velocity, elapsed_us,
        output ready
    );
endinterface

`default_nettype wire

/* design/pwsf_out_if.sv */
`default_nettype none

interface pwsf_out_if
    import pwsf_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [DUTY_W-1:0] duty;
    logic signed [ERR_W-1:0]  error_out;
    logic                     clamped;

    modport source (
        output valid, duty, error_out, clamped,
        input  ready
    );

    modport sink (
        input  valid, duty, error_out, clamped,
        output ready
    );
endinterface

`default_nettype wire

/* design/pid_with_static_feedforward_core.sv */
// PID controller with static friction feedforward.
// Channels: sample (sink) takes one control step per beat: mode, restart,
// measured, setpoint, velocity and elapsed_us. result (source) gives one beat
// per step: duty (Q1.15, saturated to +/-32767), error_out and clamped.
// Gains and the integral limit must be written by the user on the cfg_* port
// only while idle; the block itself does not enforce it. All products run on
// one 32x16 multiply-accumulate unit, four digits per product, plus a
// radix-4 divider for the derivative rate. A step with the derivative off
// (restart, or elapsed_us of zero) runs the P and I products; with the
// derivative on it also runs the rate product, the divide steps and the D
// product. One step is in flight at a time; sample.ready is high only while
// idle, so no new sample is taken until the current step has finished.
// The finished result sits in an output register, so a new sample is taken
// while that beat still waits. If result is stalled when the next step
// finishes, that step holds in its last state until the register frees.
// Reset clears the gains, sets the integral limit to all ones, and zeroes
// the accumulator and the stored error.
`default_nettype none

module pid_with_static_feedforward_core
    import pwsf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    pwsf_in_if.sink                    sample,
    pwsf_out_if.source                 result
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_POST  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    localparam logic [1:0] JOB_P    = 2'd0;
    localparam logic [1:0] JOB_I    = 2'd1;
    localparam logic [1:0] JOB_RATE = 2'd2;
    localparam logic [1:0] JOB_D    = 2'd3;

    localparam int MB_W       = 64;              // multiplicand magnitude width
    localparam int DIG_W      = 16;
    localparam int PP_W       = GAIN_W + DIG_W;
    localparam int PROD_W     = GAIN_W + MB_W;
    localparam int MUL_DIGITS = MB_W / DIG_W;
    localparam int QUOT_W     = 54;              // |diff| * 1e6 < 2^53
    localparam int DIV_STEPS  = QUOT_W / 2;
    localparam int REM_W      = ELAPSED_W + 1;
    localparam int DIFF_W     = ERR_W + 1;

    localparam logic [PROD_W-1:0] TERM_LIM = PROD_W'(1) << TERM_LIM_LOG;
    localparam logic signed [63:0] ONE2 = 64'sd1 <<< (GAIN_FRAC_BITS + 1);
    localparam int SH_R = (GAIN_FRAC_BITS >= 15) ? GAIN_FRAC_BITS - 15 : 0;
    localparam int SH_L = (GAIN_FRAC_BITS < 15) ? 15 - GAIN_FRAC_BITS : 0;
    localparam logic signed [63:0] DUTY_MAX = 64'sd32767;
    localparam logic [63:0] ACC_MAX = (64'd1 << (ACC_WIDTH - 1)) - 64'd1;

    // Control and state
    logic [2:0]                   state_reg;
    logic [1:0]                   job_reg;
    logic [4:0]                   cnt_reg;
    logic                         out_valid_reg;
    logic signed [GAIN_W-1:0]     gain_p_reg, gain_i_reg, gain_d_reg, gain_static_reg;
    logic        [LIMIT_W-1:0]    limit_reg;
    logic signed [ACC_WIDTH-1:0]  acc_reg;
    logic signed [ERR_W-1:0]      prev_reg;

    // Datapath
    logic signed [ERR_W-1:0]      error_reg;
    logic        [ELAPSED_W-1:0]  elapsed_reg;
    logic                         d_en_reg;
    logic        [GAIN_W-1:0]     mag_a_reg;
    logic        [MB_W-1:0]       mag_b_reg;
    logic                         neg_reg;
    logic                         rate_neg_reg;
    logic        [PROD_W-1:0]     prod_reg;
    logic        [QUOT_W-1:0]     num_reg;
    logic        [REM_W-1:0]      rem_reg;
    logic signed [63:0]           total_reg;
    logic signed [DUTY_W-1:0]     duty_reg;
    logic signed [ERR_W-1:0]      err_out_reg;
    logic                         clamped_reg;

    logic                         accept;
    logic                         fin_go;
    logic signed [ERR_W-1:0]      err_in;
    logic signed [DATA_W:0]       sgn_src;
    logic signed [63:0]           s_term;
    logic        [GAIN_W-1:0]     gp_mag, gi_mag, gd_mag;
    logic        [ACC_WIDTH-1:0]  acc_mag;
    logic        [ERR_W-1:0]      err_mag;
    logic signed [DIFF_W-1:0]     diff;
    logic        [DIFF_W-1:0]     diff_mag;
    logic        [PP_W-1:0]       pp;
    logic        [60:0]           term_mag;
    logic signed [63:0]           term;
    logic        [REM_W-1:0]      rem_c, trial;
    logic        [QUOT_W-1:0]     num_c;
    logic signed [63:0]           tc, q15;
    logic signed [DUTY_W-1:0]     duty_c;
    logic                         clamped_c;
    logic        [63:0]           lim;
    logic signed [64:0]           acc_sum, lim_s;
    logic signed [ACC_WIDTH-1:0]  acc_new;

    assign sample.ready     = (state_reg == S_IDLE);
    assign accept           = sample.valid && sample.ready;
    assign fin_go           = (state_reg == S_FIN) && (!out_valid_reg || result.ready);
    assign result.valid     = out_valid_reg;
    assign result.duty      = duty_reg;
    assign result.error_out = err_out_reg;
    assign result.clamped   = clamped_reg;

    // Error and the static feedforward term at accept
    assign err_in  = ERR_W'(sample.setpoint) - ERR_W'(sample.measured);
    assign sgn_src = sample.mode ? (DATA_W+1)'(sample.velocity) : err_in;

    always_comb
    begin
        if (sgn_src > 0)
            s_term = 64'(gain_static_reg);
        else if (sgn_src < 0)
            s_term = -64'(gain_static_reg);
        else
            s_term = '0;
    end

    assign gp_mag   = gain_p_reg[GAIN_W-1] ? ~gain_p_reg + 1'b1 : gain_p_reg;
    assign gi_mag   = gain_i_reg[GAIN_W-1] ? ~gain_i_reg + 1'b1 : gain_i_reg;
    assign gd_mag   = gain_d_reg[GAIN_W-1] ? ~gain_d_reg + 1'b1 : gain_d_reg;
    assign acc_mag  = acc_reg[ACC_WIDTH-1] ? ~acc_reg + 1'b1 : acc_reg;
    assign err_mag  = error_reg[ERR_W-1] ? ~error_reg + 1'b1 : error_reg;
    assign diff     = DIFF_W'(error_reg) - DIFF_W'(prev_reg);
    assign diff_mag = diff[DIFF_W-1] ? ~diff + 1'b1 : diff;

    // Shared multiply unit: one 32x16 digit product per cycle, MSB digit first
    assign pp = mag_a_reg * mag_b_reg[MB_W-1 -: DIG_W];

    // Saturated signed term from the finished product
    assign term_mag = (prod_reg > TERM_LIM) ? TERM_LIM[60:0] : prod_reg[60:0];
    assign term     = neg_reg ? -$signed({3'b0, term_mag}) : $signed({3'b0, term_mag});

    // Radix-4 restoring divide step
    always_comb
    begin
        rem_c = rem_reg;
        num_c = num_reg;
        trial = '0;
        for (int k = 0; k < 2; k++)
        begin
            trial = {rem_c[REM_W-2:0], num_c[QUOT_W-1]};
            num_c = {num_c[QUOT_W-2:0], 1'b0};
            if (trial >= {1'b0, elapsed_reg})
            begin
                rem_c    = trial - {1'b0, elapsed_reg};
                num_c[0] = 1'b1;
            end
            else
            begin
                rem_c = trial;
            end
        end
    end

    // Duty conversion: clamp to +/-2, rescale to Q1.15 (floor), saturate
    always_comb
    begin
        if (total_reg > ONE2)
            tc = ONE2;
        else if (total_reg < -ONE2)
            tc = -ONE2;
        else
            tc = total_reg;
        if (GAIN_FRAC_BITS >= 15)
            q15 = tc >>> SH_R;
        else
            q15 = tc <<< SH_L;
        clamped_c = 1'b0;
        if (q15 > DUTY_MAX)
        begin
            duty_c    = DUTY_W'(DUTY_MAX);
            clamped_c = 1'b1;
        end
        else if (q15 < -DUTY_MAX)
        begin
            duty_c    = DUTY_W'(-DUTY_MAX);
            clamped_c = 1'b1;
        end
        else
        begin
            duty_c = q15[DUTY_W-1:0];
        end
    end

    // Accumulator update with clamp to the tighter of the two bounds
    always_comb
    begin
        lim     = (64'(limit_reg) < ACC_MAX) ? 64'(limit_reg) : ACC_MAX;
        lim_s   = $signed({1'b0, lim});
        acc_sum = 65'(acc_reg) + 65'(error_reg);
        if (acc_sum > lim_s)
            acc_new = ACC_WIDTH'(lim_s);
        else if (acc_sum < -lim_s)
            acc_new = ACC_WIDTH'(-lim_s);
        else
            acc_new = ACC_WIDTH'(acc_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            job_reg         <= JOB_P;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
            gain_p_reg      <= '0;
            gain_i_reg      <= '0;
            gain_d_reg      <= '0;
            gain_static_reg <= '0;
            limit_reg       <= '1;
            acc_reg         <= '0;
            prev_reg        <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_GAIN_P:         gain_p_reg      <= cfg_data[GAIN_W-1:0];
                    REG_GAIN_I:         gain_i_reg      <= cfg_data[GAIN_W-1:0];
                    REG_GAIN_D:         gain_d_reg      <= cfg_data[GAIN_W-1:0];
                    REG_GAIN_STATIC:    gain_static_reg <= cfg_data[GAIN_W-1:0];
                    REG_INTEGRAL_LIMIT: limit_reg       <= cfg_data[LIMIT_W-1:0];
                    default:            ;
                endcase
            end

            if (fin_go)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (sample.restart)
                        begin
                            acc_reg  <= '0;
                            prev_reg <= '0;
                        end
                        job_reg   <= JOB_P;
                        state_reg <= S_SETUP;
                    end
                end
                S_SETUP:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(MUL_DIGITS - 1))
                        state_reg <= S_POST;
                end
                S_POST:
                begin
                    cnt_reg <= '0;
                    unique case (job_reg)
                        JOB_P:
                        begin
                            job_reg   <= JOB_I;
                            state_reg <= S_SETUP;
                        end
                        JOB_I:
                        begin
                            if (d_en_reg)
                            begin
                                job_reg   <= JOB_RATE;
                                state_reg <= S_SETUP;
                            end
                            else
                            begin
                                state_reg <= S_FIN;
                            end
                        end
                        JOB_RATE: state_reg <= S_DIV;
                        JOB_D:    state_reg <= S_FIN;
                        default:  state_reg <= S_FIN;
                    endcase
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(DIV_STEPS - 1))
                    begin
                        job_reg   <= JOB_D;
                        state_reg <= S_SETUP;
                    end
                end
                S_FIN:
                begin
                    if (fin_go)
                    begin
                        acc_reg   <= acc_new;
                        prev_reg  <= error_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    error_reg   <= err_in;
                    elapsed_reg <= sample.elapsed_us;
                    d_en_reg    <= !sample.restart && (sample.elapsed_us != '0);
                    total_reg   <= s_term;
                end
            end
            S_SETUP:
            begin
                prod_reg <= '0;
                unique case (job_reg)
                    JOB_P:
                    begin
                        mag_a_reg <= gp_mag;
                        mag_b_reg <= MB_W'(err_mag);
                        neg_reg   <= gain_p_reg[GAIN_W-1] ^ error_reg[ERR_W-1];
                    end
                    JOB_I:
                    begin
                        mag_a_reg <= gi_mag;
                        mag_b_reg <= MB_W'(acc_mag);
                        neg_reg   <= gain_i_reg[GAIN_W-1] ^ acc_reg[ACC_WIDTH-1];
                    end
                    JOB_RATE:
                    begin
                        mag_a_reg    <= GAIN_W'(USEC_PER_SEC);
                        mag_b_reg    <= MB_W'(diff_mag);
                        neg_reg      <= diff[DIFF_W-1];
                        rate_neg_reg <= diff[DIFF_W-1];
                    end
                    JOB_D:
                    begin
                        mag_a_reg <= gd_mag;
                        mag_b_reg <= MB_W'(num_reg);
                        neg_reg   <= gain_d_reg[GAIN_W-1] ^ rate_neg_reg;
                    end
                    default: ;
                endcase
            end
            S_MUL:
            begin
                prod_reg  <= {prod_reg[PROD_W-DIG_W-1:0], DIG_W'(0)} + PROD_W'(pp);
                mag_b_reg <= {mag_b_reg[MB_W-DIG_W-1:0], DIG_W'(0)};
            end
            S_POST:
            begin
                if (job_reg == JOB_RATE)
                begin
                    num_reg <= prod_reg[QUOT_W-1:0];
                    rem_reg <= '0;
                end
                else
                begin
                    total_reg <= total_reg + term;
                end
            end
            S_DIV:
            begin
                num_reg <= num_c;
                rem_reg <= rem_c;
            end
            S_FIN:
            begin
                if (fin_go)
                begin
                    duty_reg    <= duty_c;
                    err_out_reg <= error_reg;
                    clamped_reg <= clamped_c;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire
